>>> src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int POS_W   = 8;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int KIND_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOCATE = 2'd1,
		KIND_GET    = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_POSITION = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VAL_W-1:0] val_t;

endpackage

>>> src/sle_if.sv
// ----------------------------------------------------------------------------
// sle_req_if / sle_rsp_if
// Request and response channels of the list engine (valid/ready).
// ----------------------------------------------------------------------------
interface sle_req_if import sle_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	pos_t  position;
	val_t  value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	pos_t    found_position;
	val_t    read_value;
	pos_t    count;

	modport source (output valid, status, found_position, read_value, count, input ready);
	modport sink   (input valid, status, found_position, read_value, count, output ready);
endinterface

>>> src/sle_store.sv
// ----------------------------------------------------------------------------
// sle_store
// List storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_store import sle_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  val_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output val_t          rdata
);

	val_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: decodes a beat, walks the store for insert shifts and
// locate scans, and holds the response register.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; #(
	parameter int CAPACITY = 128,
	parameter int AW       = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	sle_req_if.sink       req,
	sle_rsp_if.source     rsp,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output val_t          mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  val_t          mem_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_W + 1) ? CW : POS_W + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SHIFT, S_INS_WR, S_LOCATE, S_GET_RD, S_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	pos_t          pos_q;
	val_t          val_q;
	logic          pend_s1;
	logic [AW-1:0] waddr_s1;
	logic          cmp_s1;
	logic [CW-1:0] cidx_s1;
	status_t       res_status_q;
	pos_t          res_found_q;
	val_t          res_read_q;
	logic          out_valid_q;

	logic [MW-1:0] cnt_ext, in_pos_ext, pos_ext;
	logic          accept, in_pos_zero, ins_bad, get_bad, is_last_shift, scan_more;
	logic          out_load, loc_hit;

	assign cnt_ext       = MW'(count_q);
	assign in_pos_ext    = MW'(req.position);
	assign pos_ext       = MW'(pos_q);
	assign in_pos_zero   = (req.position == '0);
	assign ins_bad       = in_pos_zero || (in_pos_ext > cnt_ext + MW'(1));
	assign get_bad       = in_pos_zero || (in_pos_ext > cnt_ext);
	assign accept        = req.valid && req.ready;
	assign is_last_shift = (MW'(idx_q) == pos_ext - MW'(1));
	assign scan_more     = (idx_q < count_q);
	assign loc_hit       = cmp_s1 && (mem_rdata == val_q);
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);

	// read port: get in the accept cycle, shift/scan while walking
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				mem_re    = accept && (req.kind == KIND_GET) && !get_bad;
				mem_raddr = AW'(in_pos_ext - MW'(1));
			end
			S_SHIFT:  mem_re = 1'b1;
			S_LOCATE: mem_re = !loc_hit && scan_more;
			default:  mem_re = 1'b0;
		endcase
	end

	// write port: shift writes take priority over the final insert write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_s1;
		mem_wdata = mem_rdata;
		if (pend_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_INS_WR) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(pos_ext - MW'(1));
			mem_wdata = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			val_q        <= '0;
			pend_s1      <= 1'b0;
			waddr_s1     <= '0;
			cmp_s1       <= 1'b0;
			cidx_s1      <= '0;
			out_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			res_read_q   <= '0;
		end else begin
			pend_s1  <= (state_q == S_SHIFT);
			waddr_s1 <= idx_q[AW-1:0] + AW'(1);
			cmp_s1   <= (state_q == S_LOCATE) && !loc_hit && scan_more;
			cidx_s1  <= idx_q;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q        <= req.position;
						val_q        <= req.value;
						res_status_q <= ST_OK;
						res_found_q  <= '0;
						res_read_q   <= '0;
						idx_q        <= '0;
						case (req.kind)
							KIND_INSERT: begin
								if (ins_bad) begin
									res_status_q <= ST_POSITION;
									state_q      <= S_DONE;
								end else if (count_q == CW'(CAPACITY)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else if (in_pos_ext == cnt_ext + MW'(1)) begin
									state_q <= S_INS_WR;
								end else begin
									idx_q   <= count_q - CW'(1);
									state_q <= S_SHIFT;
								end
							end
							KIND_LOCATE: begin
								state_q <= (count_q == '0) ? S_DONE : S_LOCATE;
							end
							KIND_GET: begin
								if (get_bad) begin
									res_status_q <= ST_POSITION;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_GET_RD;
								end
							end
							default: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// move entry idx up by one; stop after the insert slot
					if (is_last_shift) begin
						state_q <= S_INS_WR;
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				S_INS_WR: begin
					if (!pend_s1) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_LOCATE: begin
					if (loc_hit) begin
						res_found_q <= POS_W'(cidx_s1 + CW'(1));
						state_q     <= S_DONE;
					end else if (scan_more) begin
						idx_q <= idx_q + CW'(1);
					end else if (!cmp_s1) begin
						state_q <= S_DONE;
					end
				end
				S_GET_RD: begin
					res_read_q <= mem_rdata;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.status         <= res_status_q;
			rsp.found_position <= res_found_q;
			rsp.read_value     <= res_read_q;
			rsp.count          <= POS_W'(count_q);
		end
	end

	assign rsp.valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + CW'(1) || count_q == '0)
		else $error("element count moved by more than one");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("read and write hit the same entry");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_SHIFT || state_q == S_INS_WR)
		else $error("store written outside an insert");

endmodule

>>> src/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit values with insert, locate, get and clear.
//
//   channel | dir | payload
//   --------+-----+-----------------------------------------------
//   req     | in  | kind, position, value
//   rsp     | out | status, found_position, read_value, count
//
// One request at a time. Clear and rejected requests, and locate on an empty
// list, go straight to the response; get reads one entry and an append
// writes one entry. Insert and locate walk the store one entry per cycle.
// The store needs no clearing after reset; only entries below count are read.
// A stalled response holds in its register while the next request is taken.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	val_t          mem_wdata, mem_rdata;

	sle_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sle_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
